### rtl/core/fbi_pkg.sv
// Shared types, constants and the prime term selector for the FNV-1a bucket indexer.
package fbi_pkg;

   localparam int HASH_WIDTH  = 64;
   localparam int INDEX_WIDTH = 16;
   localparam int MUL_STEPS   = 7;
   localparam int SEL_WIDTH   = $clog2(MUL_STEPS);
   localparam int DIV_STEPS   = HASH_WIDTH;
   localparam int CNT_WIDTH   = $clog2(DIV_STEPS);
   localparam int COUNT_RESET = 400;

   localparam logic [HASH_WIDTH-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   typedef enum logic [1:0] {
      FBI_IDLE,
      FBI_MUL,
      FBI_DIV,
      FBI_DONE
   } fbi_state_type;

   typedef struct packed {
      logic                 take;
      logic                 take_empty;
      logic                 mul_step_en;
      logic [SEL_WIDTH-1:0] mul_sel;
      logic                 mul_last;
      logic                 mul_to_div;
      logic                 div_step_en;
      logic                 emit;
   } fbi_ctl_type;

   // The FNV prime 0x100000001b3 has bits 0, 1, 4, 5, 7, 8 and 40 set.
   // Each multiply pass adds one shifted copy of the operand.
   function automatic logic [HASH_WIDTH-1:0] prime_term(input logic [HASH_WIDTH-1:0] x,
                                                        input logic [SEL_WIDTH-1:0] sel);
      logic [HASH_WIDTH-1:0] term;
      case (sel)
         3'd0: term = x;
         3'd1: term = x << 1;
         3'd2: term = x << 4;
         3'd3: term = x << 5;
         3'd4: term = x << 7;
         3'd5: term = x << 8;
         default: term = x << 40;
      endcase
      return term;
   endfunction

endpackage

### rtl/core/fbi_alu.sv
// Shared 64-bit adder/subtractor used by both the multiply and the division passes.
module fbi_alu (
   input  logic [fbi_pkg::HASH_WIDTH-1:0] op_a,
   input  logic [fbi_pkg::HASH_WIDTH-1:0] op_b,
   input  logic                           sub,
   output logic [fbi_pkg::HASH_WIDTH-1:0] sum,
   output logic                           carry_out
);

   logic [fbi_pkg::HASH_WIDTH-1:0] op_b_eff;
   logic [fbi_pkg::HASH_WIDTH:0]   total;

   // For a subtract, a carry out means no borrow, so op_a >= op_b.
   assign op_b_eff  = sub ? ~op_b : op_b;
   assign total     = {1'b0, op_a} + {1'b0, op_b_eff} + (fbi_pkg::HASH_WIDTH+1)'(sub);
   assign sum       = total[fbi_pkg::HASH_WIDTH-1:0];
   assign carry_out = total[fbi_pkg::HASH_WIDTH];

endmodule

### rtl/core/fbi_ctrl.sv
// Sequencer that steps the shared adder through the multiply and division passes.
module fbi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_byte,
   input  logic                 req_empty_key,
   input  logic                 out_free,
   output logic                 req_stall,
   output fbi_pkg::fbi_ctl_type ctl
);

   fbi_pkg::fbi_state_type state_ff, state_in;
   logic [fbi_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic last_ff, last_in;
   logic mul_end;
   logic div_end;

   assign mul_end = (cnt_ff == fbi_pkg::CNT_WIDTH'(fbi_pkg::MUL_STEPS - 1));
   assign div_end = (cnt_ff == fbi_pkg::CNT_WIDTH'(fbi_pkg::DIV_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbi_pkg::FBI_IDLE: begin
            if (req_valid) begin
               state_in = req_empty_key ? fbi_pkg::FBI_DIV : fbi_pkg::FBI_MUL;
            end
         end
         fbi_pkg::FBI_MUL: begin
            if (mul_end) begin
               state_in = last_ff ? fbi_pkg::FBI_DIV : fbi_pkg::FBI_IDLE;
            end
         end
         fbi_pkg::FBI_DIV: begin
            if (div_end) begin
               state_in = fbi_pkg::FBI_DONE;
            end
         end
         fbi_pkg::FBI_DONE: begin
            if (out_free) begin
               state_in = fbi_pkg::FBI_IDLE;
            end
         end
         default: state_in = fbi_pkg::FBI_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl         = '0;
      req_stall   = 1'b1;
      ctl.mul_sel = cnt_ff[fbi_pkg::SEL_WIDTH-1:0];
      unique case (state_ff)
         fbi_pkg::FBI_IDLE: begin
            req_stall      = 1'b0;
            ctl.take       = req_valid;
            ctl.take_empty = req_valid & req_empty_key;
         end
         fbi_pkg::FBI_MUL: begin
            ctl.mul_step_en = 1'b1;
            ctl.mul_last    = mul_end;
            ctl.mul_to_div  = mul_end & last_ff;
         end
         fbi_pkg::FBI_DIV: begin
            ctl.div_step_en = 1'b1;
         end
         fbi_pkg::FBI_DONE: begin
            ctl.emit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      cnt_in  = '0;
      last_in = last_ff;
      if (ctl.take) begin
         last_in = req_last_byte;
      end
      if ((state_ff == fbi_pkg::FBI_MUL && !mul_end) || state_ff == fbi_pkg::FBI_DIV) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbi_pkg::FBI_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      last_ff <= last_in;
   end

`ifndef ASSERT_OFF
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.take |=> state_ff != fbi_pkg::FBI_IDLE)
      else $error("transfer accepted but sequencer stayed idle");

   a_mul_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbi_pkg::FBI_MUL |-> cnt_ff < fbi_pkg::CNT_WIDTH'(fbi_pkg::MUL_STEPS))
      else $error("multiply pass count out of range");

   a_div_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbi_pkg::FBI_DIV && div_end) |=> state_ff == fbi_pkg::FBI_DONE)
      else $error("division did not finish after its last step");
`endif

endmodule

### rtl/core/fnv1a_bucket_index.sv
// Top level of the FNV-1a 64-bit bucket indexer: hash datapath, configuration and output register.
// Key bytes arrive one per transfer and are folded into a running 64-bit FNV-1a hash; the last
// byte of a key, or an empty-key transfer, yields the hash modulo the bucket count as a 16-bit
// bucket index, and a bucket count of zero gives index 0. One shared 64-bit adder does all the
// arithmetic: each accepted byte is folded in by seven shift-add passes, one per set bit of the
// FNV prime, and a finished key or an empty key adds 64 steps of restoring division and then a
// load of the output register, which waits while the result side stalls. The input stall is
// high whenever a key byte is in work. The output register lets a finished result wait while
// the next key byte is taken in. The bucket count is written through csr_we and csr_wdata, and
// the user must do so only while the block is idle; the block itself does not enforce this.
module fnv1a_bucket_index #(
   parameter int BUCKET_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_key_byte,
   input  logic                            req_last_byte,
   input  logic                            req_empty_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fbi_pkg::INDEX_WIDTH-1:0] rsp_bucket_index,
   input  logic                            csr_we,
   input  logic [BUCKET_BITS-1:0]          csr_wdata
);

   localparam int HW = fbi_pkg::HASH_WIDTH;
   localparam logic [BUCKET_BITS-1:0] COUNT_RESET = BUCKET_BITS'(fbi_pkg::COUNT_RESET);

   fbi_pkg::fbi_ctl_type ctl;

   logic [BUCKET_BITS-1:0] count_ff, count_in;
   logic [HW-1:0] hash_ff, hash_in;
   logic [HW-1:0] work_ff, work_in;
   logic [HW-1:0] acc_ff, acc_in;
   logic [BUCKET_BITS-1:0] rem_ff, rem_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [fbi_pkg::INDEX_WIDTH-1:0] index_ff, index_in;

   logic [BUCKET_BITS:0] rem_shift;
   logic [HW-1:0] alu_a, alu_b, alu_sum;
   logic alu_sub, alu_carry;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   fbi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_empty_key (req_empty_key),
      .out_free      (out_free),
      .req_stall     (req_stall),
      .ctl           (ctl)
   );

   // Restoring division brings in one dividend bit per step, most significant first.
   assign rem_shift = {rem_ff, work_ff[HW-1]};

   always_comb begin
      if (ctl.div_step_en) begin
         alu_a   = HW'(rem_shift);
         alu_b   = HW'(count_ff);
         alu_sub = 1'b1;
      end else begin
         alu_a   = acc_ff;
         alu_b   = fbi_pkg::prime_term(work_ff, ctl.mul_sel);
         alu_sub = 1'b0;
      end
   end

   fbi_alu u_alu (
      .op_a      (alu_a),
      .op_b      (alu_b),
      .sub       (alu_sub),
      .sum       (alu_sum),
      .carry_out (alu_carry)
   );

   always_comb begin
      hash_in = hash_ff;
      work_in = work_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (ctl.take) begin
         if (ctl.take_empty) begin
            hash_in = fbi_pkg::FNV_BASIS;
            work_in = fbi_pkg::FNV_BASIS;
            rem_in  = '0;
         end else begin
            work_in = hash_ff ^ HW'(req_key_byte);
            acc_in  = '0;
         end
      end
      if (ctl.mul_step_en) begin
         acc_in = alu_sum;
         if (ctl.mul_last) begin
            hash_in = alu_sum;
            if (ctl.mul_to_div) begin
               hash_in = fbi_pkg::FNV_BASIS;
               work_in = alu_sum;
               rem_in  = '0;
            end
         end
      end
      if (ctl.div_step_en) begin
         work_in = work_ff << 1;
         rem_in  = alu_carry ? alu_sum[BUCKET_BITS-1:0] : rem_shift[BUCKET_BITS-1:0];
      end
   end

   always_comb begin
      count_in = csr_we ? csr_wdata : count_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      index_in     = index_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         index_in     = (count_ff == '0) ? '0 : fbi_pkg::INDEX_WIDTH'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= fbi_pkg::FNV_BASIS;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff  <= work_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      index_ff <= index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = index_ff;

`ifndef ASSERT_OFF
   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> out_free)
      else $error("result loaded over an untaken result");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> rsp_valid_ff)
      else $error("result loaded but output not valid");

   a_hash_restart: assert property (@(posedge clock) disable iff (reset)
      (ctl.mul_to_div || ctl.take_empty) |=> hash_ff == fbi_pkg::FNV_BASIS)
      else $error("hash not returned to offset basis at end of key");
`endif

endmodule

### sim/fnv1a_bucket_index_tb.sv
// Self-checking testbench for the FNV-1a 64-bit bucket indexer.
`timescale 1ns / 100ps

module fnv1a_bucket_index_tb;

   localparam int HW = fbi_pkg::HASH_WIDTH;
   localparam int IW = fbi_pkg::INDEX_WIDTH;
   localparam int BUCKET_BITS = 16;
   localparam logic [HW-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
   // The drain covers the processing of a final byte plus the output register.
   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_key_byte = 8'h00;
   logic                   req_last_byte = 1'b0;
   logic                   req_empty_key = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [IW-1:0]          rsp_bucket_index;
   logic                   csr_we = 1'b0;
   logic [BUCKET_BITS-1:0] csr_wdata = '0;
   // Set while the sender holds req_valid high, so it is lowered only once.
   logic                   req_active = 1'b0;

   // Predictor state and the queue of bucket indexes still to come out.
   logic [HW-1:0]          hash_state = fbi_pkg::FNV_BASIS;
   logic [BUCKET_BITS-1:0] num_buckets = BUCKET_BITS'(fbi_pkg::COUNT_RESET);
   logic [IW-1:0]          expected_buckets[$];

   int             error_count = 0;
   int             transfers_sent = 0;
   int             indexes_checked = 0;
   int             counts_written = 0;
   int             burst_left = 0;
   int             gap_max = 0;
   int             hold_request = 0;
   int             idle_cycles = 0;
   stall_mode_type stall_mode = STALL_NONE;

   fnv1a_bucket_index #(
      .BUCKET_BITS(BUCKET_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_byte(req_key_byte),
      .req_last_byte(req_last_byte),
      .req_empty_key(req_empty_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bucket_index(rsp_bucket_index),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [IW-1:0] bucket_of_hash(input logic [HW-1:0] h);
      logic [HW-1:0] rem;
      if (num_buckets == '0) begin
         return '0;
      end
      rem = h % HW'(num_buckets);
      return rem[IW-1:0];
   endfunction

   // Folds one accepted transfer into the running hash and queues any index it finishes.
   task automatic fold_transfer(input logic [7:0] kb, input logic lb, input logic ek);
      if (ek) begin
         hash_state = fbi_pkg::FNV_BASIS;
         expected_buckets.push_back(bucket_of_hash(fbi_pkg::FNV_BASIS));
      end else begin
         hash_state = (hash_state ^ HW'(kb)) * FNV_PRIME;
         if (lb) begin
            expected_buckets.push_back(bucket_of_hash(hash_state));
            hash_state = fbi_pkg::FNV_BASIS;
         end
      end
   endtask

   task automatic stop_sending();
      if (req_active) begin
         req_valid <= 1'b0;
         req_active = 1'b0;
      end
      burst_left = 0;
   endtask

   task automatic send_transfer(input logic [7:0] kb, input logic lb, input logic ek);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            stop_sending();
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_active     = 1'b1;
      req_key_byte  <= kb;
      req_last_byte <= lb;
      req_empty_key <= ek;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_transfer(kb, lb, ek);
      transfers_sent++;
   endtask

   task automatic send_key(input int len);
      for (int i = 0; i < len; i++) begin
         send_transfer(8'($urandom_range(0, 255)), i == len - 1, 1'b0);
      end
   endtask

   task automatic send_empty_key();
      send_transfer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   task automatic wait_until_drained();
      while (expected_buckets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_bucket_count(input logic [BUCKET_BITS-1:0] value);
      stop_sending();
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      num_buckets = value;
      counts_written++;
   endtask

   // Receiver: a long hold when one is requested, otherwise the current stall pattern.
   initial begin
      int hold_left;
      int tick;
      hold_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
               STALL_PATTERN: rsp_stall <= ((tick % 7) < 3);
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Result checker: every transfer on the result side must match the oldest prediction.
   always @(posedge clock) begin
      logic [IW-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_buckets.size() == 0) begin
            $error("bucket_index %0d arrived with no result pending", rsp_bucket_index);
            error_count++;
         end else begin
            want = expected_buckets.pop_front();
            indexes_checked++;
            if (rsp_bucket_index !== want) begin
               $error("bucket_index mismatch: expected %0d, actual %0d", want,
                      rsp_bucket_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout with %0d results still pending", expected_buckets.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_directed_keys();
      gap_max = 0;
      stall_mode = STALL_NONE;
      send_empty_key();
      send_transfer(8'h00, 1'b1, 1'b0);
      send_transfer(8'hff, 1'b1, 1'b0);
      send_transfer("a", 1'b0, 1'b0);
      send_transfer("b", 1'b0, 1'b0);
      send_transfer("c", 1'b1, 1'b0);
      send_transfer(8'h80, 1'b1, 1'b0);
      // A partial key cut short by an empty key is thrown away.
      send_transfer(8'h12, 1'b0, 1'b0);
      send_transfer(8'h34, 1'b0, 1'b0);
      send_transfer(8'hff, 1'b1, 1'b1);
      send_transfer(8'ha5, 1'b0, 1'b1);
      send_transfer(8'h7f, 1'b1, 1'b0);
      stop_sending();
   endtask

   task automatic test_bucket_extremes();
      set_bucket_count(BUCKET_BITS'(1));
      send_key(3);
      send_empty_key();
      set_bucket_count('1);
      send_key(1);
      send_key(4);
      send_empty_key();
      // A zero bucket count gives index 0.
      set_bucket_count('0);
      send_key(2);
      send_empty_key();
      set_bucket_count(BUCKET_BITS'(2));
      send_key(1);
      send_key(2);
      stop_sending();
   endtask

   // The receiver holds off long enough for the output register and the datapath to
   // fill, so the block must stall its input while the sender keeps offering keys.
   task automatic test_output_backpressure();
      set_bucket_count(BUCKET_BITS'(fbi_pkg::COUNT_RESET));
      gap_max = 0;
      stall_mode = STALL_NONE;
      hold_request = LONG_HOLD_CYCLES;
      for (int i = 0; i < 6; i++) begin
         send_key(1);
      end
      send_key(3);
      stop_sending();
   endtask

   task automatic test_random_keys(input int n_items);
      int quota;
      int sent_before;
      int pick;
      quota = n_items / 4;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_bucket_count(BUCKET_BITS'($urandom_range(1, 65535)));
            1: set_bucket_count(BUCKET_BITS'($urandom_range(1, 16)));
            2: set_bucket_count('1);
            default: set_bucket_count(BUCKET_BITS'($urandom_range(1, 65535)));
         endcase
         gap_max = (phase == 2) ? 0 : 2 + phase * 2;
         stall_mode = stall_mode_type'(phase % 3);
         sent_before = transfers_sent;
         while (transfers_sent - sent_before < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_key($urandom_range(9, 24));
               end else begin
                  send_key($urandom_range(1, 6));
               end
            end else if (pick < 90) begin
               send_empty_key();
            end else begin
               for (int i = $urandom_range(1, 4); i > 0; i--) begin
                  send_transfer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               end
               send_empty_key();
            end
         end
         stop_sending();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_keys();
      test_bucket_extremes();
      test_output_backpressure();
      test_random_keys(420);
      stop_sending();
      stall_mode = STALL_NONE;
      wait_until_drained();
      $display("Sent %0d key transfers and checked %0d bucket indexes", transfers_sent,
               indexes_checked);
      $display("Bucket count was rewritten %0d times, including 0, 1 and 65535",
               counts_written);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
